// ----- rtl/core/eht_pkg.sv -----
package eht_pkg;

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int DEPTH_W  = 3;
   localparam int CFG_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_W    = 16;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DELETED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERFLOW   = 2'd2;

   localparam logic [2:0] RST_INIT_DEPTH = 3'd1;
   localparam logic [2:0] RST_CAPACITY   = 3'd2;
   localparam logic       RST_OVERFLOW   = 1'b0;

   typedef struct packed {
      logic [2:0] init_depth;
      logic [2:0] capacity;
      logic       overflow;
   } cfg_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth;
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// ----- rtl/core/eht_dir.sv -----
module eht_dir #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] dir_mem_ff [1 << ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dir_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= dir_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/eht_bkt.sv -----
module eht_bkt #(
   parameter int KA_W  = 9,
   parameter int KEY_W = 31,
   parameter int MA_W  = 6,
   parameter int MT_W  = 8
) (
   input  logic             clock,
   input  logic             key_wr_en,
   input  logic [KA_W-1:0]  key_wr_addr,
   input  logic [KEY_W-1:0] key_wr_data,
   input  logic [KA_W-1:0]  key_rd_addr,
   output logic [KEY_W-1:0] key_rd_data,
   input  logic             meta_wr_en,
   input  logic [MA_W-1:0]  meta_wr_addr,
   input  logic [MT_W-1:0]  meta_wr_data,
   input  logic [MA_W-1:0]  meta_rd_addr,
   output logic [MT_W-1:0]  meta_rd_data
);

   logic [KEY_W-1:0] key_mem_ff [1 << KA_W];
   logic [MT_W-1:0]  meta_mem_ff [1 << MA_W];
   logic [KEY_W-1:0] key_rd_ff;
   logic [MT_W-1:0]  meta_rd_ff;

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem_ff[key_wr_addr] <= key_wr_data;
      end
      key_rd_ff <= key_mem_ff[key_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem_ff[meta_wr_addr] <= meta_wr_data;
      end
      meta_rd_ff <= meta_mem_ff[meta_rd_addr];
   end

   assign key_rd_data  = key_rd_ff;
   assign meta_rd_data = meta_rd_ff;

endmodule

// ----- rtl/core/eht_ctrl.sv -----
module eht_ctrl #(
   parameter int MAX_GLOBAL_DEPTH = 6,
   parameter int NUM_BUCKETS      = 64,
   parameter int MAX_PAGE_SLOTS   = 4,
   parameter int KEY_BITS         = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  eht_pkg::cfg_type            cfg,
   input  logic                        clear_req,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [eht_pkg::FUNC_W-1:0]  req_func,
   input  logic [KEY_BITS-1:0]         req_key,
   output logic                        res_valid,
   input  logic                        res_ready,
   output eht_pkg::result_type         res
);

   localparam int DA_W    = MAX_GLOBAL_DEPTH;
   localparam int DIR_SLOTS = 1 << MAX_GLOBAL_DEPTH;
   localparam int BK_W    = $clog2(NUM_BUCKETS);
   localparam int SLOTS   = 2 * MAX_PAGE_SLOTS;
   localparam int SL_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KA_W    = BK_W + SL_W;
   localparam int CN_W    = $clog2(SLOTS + 1);
   localparam int GD_W    = $clog2(MAX_GLOBAL_DEPTH + 1);
   localparam int MT_W    = 1 + GD_W + CN_W;
   localparam int FIT_D   = $clog2(NUM_BUCKETS + 1) - 1;
   localparam int MAXD    = (MAX_GLOBAL_DEPTH < FIT_D) ? MAX_GLOBAL_DEPTH : FIT_D;
   localparam int CLR_LEN = (DIR_SLOTS > NUM_BUCKETS) ? DIR_SLOTS : NUM_BUCKETS;
   localparam int CLR_W   = $clog2(CLR_LEN);
   localparam int KX_W    = (KEY_BITS > DA_W) ? KEY_BITS : DA_W;
   localparam int SLOT_W  = eht_pkg::SLOT_W;
   localparam int DEPTH_W = eht_pkg::DEPTH_W;

   typedef enum logic [26:0] {
      ST_CLEAR   = 27'b1 << 0,
      ST_IDLE    = 27'b1 << 1,
      ST_DIR     = 27'b1 << 2,
      ST_BKT     = 27'b1 << 3,
      ST_META    = 27'b1 << 4,
      ST_KRD     = 27'b1 << 5,
      ST_KCHK    = 27'b1 << 6,
      ST_DSH     = 27'b1 << 7,
      ST_DSHW    = 27'b1 << 8,
      ST_DMETA   = 27'b1 << 9,
      ST_BUD     = 27'b1 << 10,
      ST_BMETA   = 27'b1 << 11,
      ST_MDIR_RD = 27'b1 << 12,
      ST_MDIR_WR = 27'b1 << 13,
      ST_MMETA   = 27'b1 << 14,
      ST_MMETA2  = 27'b1 << 15,
      ST_FREE    = 27'b1 << 16,
      ST_FCHK    = 27'b1 << 17,
      ST_DBL_RD  = 27'b1 << 18,
      ST_DBL_WR  = 27'b1 << 19,
      ST_SPL_RD  = 27'b1 << 20,
      ST_SPL_WR  = 27'b1 << 21,
      ST_SPL_MB  = 27'b1 << 22,
      ST_SPL_MN  = 27'b1 << 23,
      ST_SDIR_RD = 27'b1 << 24,
      ST_SDIR_WR = 27'b1 << 25,
      ST_DONE    = 27'b1 << 26
   } state_type;

   function automatic logic [DA_W-1:0] mask_of(input logic [GD_W-1:0] g);
      mask_of = ~({DA_W{1'b1}} << g);
   endfunction

   state_type                       state_ff, state_in;
   logic [eht_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [KEY_BITS-1:0]             key_ff, key_in;
   logic [GD_W-1:0]                 gd_ff, gd_in;
   logic [BK_W-1:0]                 b_ff, b_in, nb_ff, nb_in, bud_ff, bud_in;
   logic [CN_W-1:0]                 cnt_ff, cnt_in, idx_ff, idx_in;
   logic [CN_W-1:0]                 keep_ff, keep_in, ncnt_ff, ncnt_in;
   logic [CN_W-1:0]                 budcnt_ff, budcnt_in;
   logic                            inuse_ff, inuse_in, budinuse_ff, budinuse_in;
   logic [GD_W-1:0]                 ld_ff, ld_in;
   logic [DA_W-1:0]                 sw_ff, sw_in;
   logic [BK_W-1:0]                 fj_ff, fj_in;
   logic [CLR_W-1:0]                clr_ff, clr_in;
   logic [BK_W-1:0]                 clrm_ff, clrm_in;
   logic [eht_pkg::STATUS_W-1:0]    status_ff, status_in;

   logic                            dir_we;
   logic [DA_W-1:0]                 dir_waddr, dir_raddr;
   logic [BK_W-1:0]                 dir_wdata, dir_rdata;
   logic                            key_we;
   logic [KA_W-1:0]                 key_waddr, key_raddr;
   logic [KEY_BITS-1:0]             key_wdata, key_rdata;
   logic                            meta_we;
   logic [BK_W-1:0]                 meta_waddr, meta_raddr;
   logic [MT_W-1:0]                 meta_wdata, meta_rdata;

   logic [CN_W-1:0]                 m_cnt;
   logic [GD_W-1:0]                 m_depth;
   logic                            m_inuse;
   logic [2:0]                      cap_raw;
   logic [CN_W-1:0]                 cap_c, room;
   logic [GD_W-1:0]                 init_d;
   logic [KX_W-1:0]                 key_x;
   logic [DA_W-1:0]                 mask, slot;

   eht_dir #(.ADDR_W(DA_W), .DATA_W(BK_W)) u_dir (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_addr (dir_raddr),
      .rd_data (dir_rdata)
   );

   eht_bkt #(.KA_W(KA_W), .KEY_W(KEY_BITS), .MA_W(BK_W), .MT_W(MT_W)) u_bkt (
      .clock        (clock),
      .key_wr_en    (key_we),
      .key_wr_addr  (key_waddr),
      .key_wr_data  (key_wdata),
      .key_rd_addr  (key_raddr),
      .key_rd_data  (key_rdata),
      .meta_wr_en   (meta_we),
      .meta_wr_addr (meta_waddr),
      .meta_wr_data (meta_wdata),
      .meta_rd_addr (meta_raddr),
      .meta_rd_data (meta_rdata)
   );

   assign m_cnt   = meta_rdata[CN_W-1:0];
   assign m_depth = meta_rdata[CN_W+GD_W-1:CN_W];
   assign m_inuse = meta_rdata[MT_W-1];

   assign cap_raw = cfg.capacity;
   always_comb begin
      priority if (cap_raw == 3'd0) begin
         cap_c = CN_W'(1);
      end else if (32'(cap_raw) > MAX_PAGE_SLOTS) begin
         cap_c = CN_W'(MAX_PAGE_SLOTS);
      end else begin
         cap_c = CN_W'(cap_raw);
      end
      room = cfg.overflow ? CN_W'(cap_c << 1) : cap_c;
      if (32'(cfg.init_depth) > MAXD) begin
         init_d = GD_W'(MAXD);
      end else begin
         init_d = GD_W'(cfg.init_depth);
      end
   end

   assign key_x = KX_W'(key_ff);
   assign mask  = mask_of(gd_ff);
   assign slot  = key_x[DA_W-1:0] & mask;

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      gd_in       = gd_ff;
      b_in        = b_ff;
      nb_in       = nb_ff;
      bud_in      = bud_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      keep_in     = keep_ff;
      ncnt_in     = ncnt_ff;
      budcnt_in   = budcnt_ff;
      inuse_in    = inuse_ff;
      budinuse_in = budinuse_ff;
      ld_in       = ld_ff;
      sw_in       = sw_ff;
      fj_in       = fj_ff;
      clr_in      = clr_ff;
      clrm_in     = clrm_ff;
      status_in   = status_ff;
      dir_we      = 1'b0;
      dir_waddr   = sw_ff;
      dir_wdata   = nb_ff;
      dir_raddr   = sw_ff;
      key_we      = 1'b0;
      key_waddr   = {b_ff, idx_ff[SL_W-1:0]};
      key_wdata   = key_rdata;
      key_raddr   = {b_ff, idx_ff[SL_W-1:0]};
      meta_we     = 1'b0;
      meta_waddr  = b_ff;
      meta_wdata  = {inuse_ff, ld_ff, cnt_ff};
      meta_raddr  = b_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            gd_in      = init_d;
            dir_we     = (32'(clr_ff) < DIR_SLOTS);
            dir_waddr  = DA_W'(clr_ff);
            dir_wdata  = clrm_ff;
            meta_we    = (32'(clr_ff) < NUM_BUCKETS);
            meta_waddr = BK_W'(clr_ff);
            meta_wdata = {((clr_ff >> init_d) == '0), init_d, CN_W'(0)};
            clrm_in    = (32'(clrm_ff) == NUM_BUCKETS - 1) ? '0 : clrm_ff + 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (32'(clr_ff) == CLR_LEN - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_key;
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            dir_raddr = slot;
            state_in  = ST_BKT;
         end
         ST_BKT: begin
            b_in       = dir_rdata;
            meta_raddr = dir_rdata;
            state_in   = ST_META;
         end
         ST_META: begin
            cnt_in   = m_cnt;
            ld_in    = m_depth;
            inuse_in = m_inuse;
            idx_in   = '0;
            if (func_ff == eht_pkg::FUNC_INSERT) begin
               priority if (m_cnt < room) begin
                  key_we     = 1'b1;
                  key_waddr  = {b_ff, m_cnt[SL_W-1:0]};
                  key_wdata  = key_ff;
                  meta_we    = 1'b1;
                  meta_wdata = {m_inuse, m_depth, m_cnt + 1'b1};
                  status_in  = eht_pkg::STATUS_INSERTED;
                  state_in   = ST_DONE;
               end else if (m_depth >= gd_ff && 32'(gd_ff) >= MAX_GLOBAL_DEPTH) begin
                  status_in = eht_pkg::STATUS_FULL;
                  state_in  = ST_DONE;
               end else begin
                  fj_in    = '0;
                  state_in = ST_FREE;
               end
            end else begin
               state_in = ST_KRD;
            end
         end
         ST_KRD: begin
            if (idx_ff < cnt_ff && 32'(idx_ff) < SLOTS) begin
               state_in = ST_KCHK;
            end else begin
               status_in = eht_pkg::STATUS_NOT_FOUND;
               state_in  = ST_DONE;
            end
         end
         ST_KCHK: begin
            if (key_rdata == key_ff) begin
               if (func_ff == eht_pkg::FUNC_DELETE) begin
                  state_in = ST_DSH;
               end else begin
                  status_in = eht_pkg::STATUS_FOUND;
                  state_in  = ST_DONE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_KRD;
            end
         end
         ST_DSH: begin
            key_raddr = {b_ff, SL_W'(idx_ff + 1'b1)};
            if (idx_ff + 1'b1 < cnt_ff) begin
               state_in = ST_DSHW;
            end else begin
               state_in = ST_DMETA;
            end
         end
         ST_DSHW: begin
            key_we   = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_DSH;
         end
         ST_DMETA: begin
            meta_we    = 1'b1;
            meta_wdata = {inuse_ff, ld_ff, cnt_ff - 1'b1};
            dir_raddr  = slot ^ (DA_W'(1) << (ld_ff - 1'b1));
            if (cnt_ff == CN_W'(1) && ld_ff != '0) begin
               state_in = ST_BUD;
            end else begin
               status_in = eht_pkg::STATUS_DELETED;
               state_in  = ST_DONE;
            end
         end
         ST_BUD: begin
            bud_in     = dir_rdata;
            meta_raddr = dir_rdata;
            state_in   = ST_BMETA;
         end
         ST_BMETA: begin
            budcnt_in   = m_cnt;
            budinuse_in = m_inuse;
            sw_in       = '0;
            if (bud_ff != b_ff && m_depth == ld_ff) begin
               state_in = ST_MDIR_RD;
            end else begin
               status_in = eht_pkg::STATUS_DELETED;
               state_in  = ST_DONE;
            end
         end
         ST_MDIR_RD: begin
            state_in = ST_MDIR_WR;
         end
         ST_MDIR_WR: begin
            dir_we    = (dir_rdata == b_ff);
            dir_wdata = bud_ff;
            if (sw_ff == mask) begin
               state_in = ST_MMETA;
            end else begin
               sw_in    = sw_ff + 1'b1;
               state_in = ST_MDIR_RD;
            end
         end
         ST_MMETA: begin
            meta_we    = 1'b1;
            meta_waddr = bud_ff;
            meta_wdata = {budinuse_ff, ld_ff - 1'b1, budcnt_ff};
            state_in   = ST_MMETA2;
         end
         ST_MMETA2: begin
            meta_we    = 1'b1;
            meta_wdata = {1'b0, GD_W'(0), CN_W'(0)};
            status_in  = eht_pkg::STATUS_DELETED;
            state_in   = ST_DONE;
         end
         ST_FREE: begin
            meta_raddr = fj_ff;
            state_in   = ST_FCHK;
         end
         ST_FCHK: begin
            idx_in  = '0;
            keep_in = '0;
            ncnt_in = '0;
            sw_in   = '0;
            priority if (!m_inuse) begin
               nb_in    = fj_ff;
               state_in = (ld_ff >= gd_ff) ? ST_DBL_RD : ST_SPL_RD;
            end else if (32'(fj_ff) == NUM_BUCKETS - 1) begin
               status_in = eht_pkg::STATUS_FULL;
               state_in  = ST_DONE;
            end else begin
               fj_in    = fj_ff + 1'b1;
               state_in = ST_FREE;
            end
         end
         ST_DBL_RD: begin
            state_in = ST_DBL_WR;
         end
         ST_DBL_WR: begin
            dir_we    = 1'b1;
            dir_waddr = sw_ff | (DA_W'(1) << gd_ff);
            dir_wdata = dir_rdata;
            if (sw_ff == mask) begin
               gd_in    = gd_ff + 1'b1;
               state_in = ST_SPL_RD;
            end else begin
               sw_in    = sw_ff + 1'b1;
               state_in = ST_DBL_RD;
            end
         end
         ST_SPL_RD: begin
            if (idx_ff < cnt_ff && 32'(idx_ff) < SLOTS) begin
               state_in = ST_SPL_WR;
            end else begin
               state_in = ST_SPL_MB;
            end
         end
         ST_SPL_WR: begin
            key_we = 1'b1;
            if (key_rdata[ld_ff]) begin
               key_waddr = {nb_ff, ncnt_ff[SL_W-1:0]};
               ncnt_in   = ncnt_ff + 1'b1;
            end else begin
               key_waddr = {b_ff, keep_ff[SL_W-1:0]};
               keep_in   = keep_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SPL_RD;
         end
         ST_SPL_MB: begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, ld_ff + 1'b1, keep_ff};
            state_in   = ST_SPL_MN;
         end
         ST_SPL_MN: begin
            meta_we    = 1'b1;
            meta_waddr = nb_ff;
            meta_wdata = {1'b1, ld_ff + 1'b1, ncnt_ff};
            sw_in      = '0;
            state_in   = ST_SDIR_RD;
         end
         ST_SDIR_RD: begin
            state_in = ST_SDIR_WR;
         end
         ST_SDIR_WR: begin
            dir_we = (dir_rdata == b_ff) && sw_ff[ld_ff];
            if (sw_ff == mask) begin
               state_in = ST_DIR;
            end else begin
               sw_in    = sw_ff + 1'b1;
               state_in = ST_SDIR_RD;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
            clrm_in  = '0;
         end
      endcase

      if (clear_req) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
         clrm_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         clrm_ff  <= '0;
         gd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         clrm_ff  <= clrm_in;
         gd_ff    <= gd_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      b_ff        <= b_in;
      nb_ff       <= nb_in;
      bud_ff      <= bud_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      keep_ff     <= keep_in;
      ncnt_ff     <= ncnt_in;
      budcnt_ff   <= budcnt_in;
      inuse_ff    <= inuse_in;
      budinuse_ff <= budinuse_in;
      ld_ff       <= ld_in;
      sw_ff       <= sw_in;
      fj_ff       <= fj_in;
      status_ff   <= status_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_DONE);
   assign res.status = status_ff;
   assign res.slot   = SLOT_W'(slot);
   assign res.depth  = DEPTH_W'(gd_ff);

   a_split_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPL_WR |-> (32'(keep_ff) + 32'(ncnt_ff)) == 32'(idx_ff))
      else $error("split bookkeeping lost a key");

   a_double_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DBL_RD |-> 32'(gd_ff) < MAX_GLOBAL_DEPTH)
      else $error("directory doubled past its limit");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !clear_req) |=> state_ff == ST_DIR)
      else $error("accepted request did not start a lookup");

   a_merge_buddy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MMETA |-> bud_ff != b_ff)
      else $error("bucket merged into itself");

endmodule

// ----- rtl/core/extendible_hash_table.sv -----
// Channel  | Ports                      | Beat contents (lowest bit first)
// req      | req_tvalid/tready/tdata    | func[1:0], key[KEY_BITS+1:2], zero fill
// rsp      | rsp_tvalid/tready/tdata    | status[2:0], slot_index[8:3], depth_now[11:9]
// csr      | csr_wr_en/index/wdata      | register index, write data (3 bits)
// One request at a time; req_tready is high only while the sequencer is idle.
// Insert with room: directory read, bucket metadata read, key and count written.
// Search: the same reads, then stored keys probed in turn. Delete: a search, later
// keys shifted down, count written; a merge check, and a merge sweeps the directory.
// Each split: buckets probed for a free one, the directory doubled if needed,
// keys moved, a sweep at the new depth, then the lookup retried. Reset and a
// write to initial_global_depth run a clearing pass with req_tready low; a result
// waiting in the output register holds the sequencer until rsp_tready.
module extendible_hash_table #(
   parameter int MAX_GLOBAL_DEPTH = 6,
   parameter int NUM_BUCKETS      = 64,
   parameter int MAX_PAGE_SLOTS   = 4,
   parameter int KEY_BITS         = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // func, key
   input  logic [((eht_pkg::FUNC_W + KEY_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status, slot_index, depth_now
   output logic [eht_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [eht_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [eht_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int FUNC_W = eht_pkg::FUNC_W;
   localparam int RSP_W  = eht_pkg::RSP_W;
   localparam int RES_W  = $bits(eht_pkg::result_type);

   eht_pkg::cfg_type    cfg_ff, cfg_in;
   eht_pkg::result_type res;
   logic [RES_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                res_valid, res_ready, clear_req;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            eht_pkg::CSR_INIT_DEPTH: cfg_in.init_depth = csr_wdata;
            eht_pkg::CSR_CAPACITY:   cfg_in.capacity   = csr_wdata;
            eht_pkg::CSR_OVERFLOW:   cfg_in.overflow   = csr_wdata[0];
            default:                 cfg_in            = cfg_ff;
         endcase
      end
   end

   assign clear_req = csr_wr_en && (csr_index == eht_pkg::CSR_INIT_DEPTH);
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_depth <= eht_pkg::RST_INIT_DEPTH;
         cfg_ff.capacity   <= eht_pkg::RST_CAPACITY;
         cfg_ff.overflow   <= eht_pkg::RST_OVERFLOW;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   eht_ctrl #(
      .MAX_GLOBAL_DEPTH (MAX_GLOBAL_DEPTH),
      .NUM_BUCKETS      (NUM_BUCKETS),
      .MAX_PAGE_SLOTS   (MAX_PAGE_SLOTS),
      .KEY_BITS         (KEY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .clear_req (clear_req),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tdata[FUNC_W-1:0]),
      .req_key   (req_tdata[FUNC_W+KEY_BITS-1:FUNC_W]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
